@@ hdl/cqsr_pkg.sv @@
package cqsr_pkg;

  localparam int WORD_W = 32;
  localparam int ITER_W = 8;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int ACC_W = 2 * WORD_W + 2;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t re;
    word_t im;
  } cplx_t;

  typedef struct packed {
    word_t start_a_re;
    word_t start_a_im;
    word_t start_b_re;
    word_t start_b_im;
  } in_item_t;

  typedef struct packed {
    word_t               root_re;
    word_t               root_im;
    logic [WORD_W-1:0]   residual_sq;
    logic [ITER_W-1:0]   iterations_used;
    logic [STAT_W-1:0]   status;
  } out_item_t;

  typedef struct packed {
    cplx_t             c0;
    cplx_t             c1;
    cplx_t             c2;
    logic [WORD_W-1:0] tol;
    logic [ITER_W-1:0] max_it;
  } cfg_t;

  localparam logic [STAT_W-1:0] ST_CONV  = 2'd0;
  localparam logic [STAT_W-1:0] ST_LIMIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_C0_RE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_C0_IM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_C1_RE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_C1_IM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_C2_RE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_C2_IM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IT = 3'd7;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_XB, OP_SQ, OP_C1, OP_C2, OP_SUM, OP_NORM,
    OP_SWAP, OP_DE, OP_NORME, OP_NUM, OP_DIVRE, OP_DIVIM, OP_ZF, OP_UPD
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_C1, S_C2, S_SUM, S_NORM, S_XB, S_TEST, S_SWAP, S_DE,
    S_NORME, S_CHKZ, S_NUM, S_DIVRE, S_DIVIM, S_ZF, S_UPD, S_CHKTOL
  } state_t;

  typedef enum logic [1:0] {
    PH_A, PH_B, PH_UPD
  } phase_t;

  typedef struct packed {
    op_t  op;
    logic sel_b;
    logic root_b;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic ut_zero;
    logic conv;
  } dp_stat_t;

endpackage

@@ hdl/cqsr_ctrl.sv @@
module cqsr_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cqsr_pkg::ITER_W-1:0]   max_it,
  input  cqsr_pkg::dp_stat_t            stat,
  output cqsr_pkg::dp_cmd_t             cmd,
  output logic                          busy,
  output logic                          out_valid,
  output logic [cqsr_pkg::ITER_W-1:0]   iters,
  output logic [cqsr_pkg::STAT_W-1:0]   status
);

  cqsr_pkg::state_t state_r, state_nxt;
  cqsr_pkg::phase_t phase_r, phase_nxt;
  logic [cqsr_pkg::ITER_W-1:0] iters_r, iters_nxt;
  logic [cqsr_pkg::STAT_W-1:0] status_r, status_nxt;
  logic rootb_r, rootb_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cqsr_pkg::S_IDLE;
      phase_r     <= cqsr_pkg::PH_A;
      iters_r     <= '0;
      status_r    <= cqsr_pkg::ST_CONV;
      rootb_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      iters_r     <= iters_nxt;
      status_r    <= status_nxt;
      rootb_r     <= rootb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    iters_nxt     = iters_r;
    status_nxt    = status_r;
    rootb_nxt     = rootb_r;
    out_valid_nxt = 1'b0;
    cmd.op        = cqsr_pkg::OP_NONE;
    cmd.sel_b     = (phase_r == cqsr_pkg::PH_B);
    cmd.root_b    = rootb_r;
    case (state_r)
      cqsr_pkg::S_IDLE: begin
        if (start) begin
          cmd.op    = cqsr_pkg::OP_LOAD;
          state_nxt = cqsr_pkg::S_SQ;
          phase_nxt = cqsr_pkg::PH_A;
          iters_nxt = '0;
        end
      end
      cqsr_pkg::S_SQ: begin
        cmd.op = cqsr_pkg::OP_SQ;
        if (stat.done) state_nxt = cqsr_pkg::S_C1;
      end
      cqsr_pkg::S_C1: begin
        cmd.op = cqsr_pkg::OP_C1;
        if (stat.done) state_nxt = cqsr_pkg::S_C2;
      end
      cqsr_pkg::S_C2: begin
        cmd.op = cqsr_pkg::OP_C2;
        if (stat.done) state_nxt = cqsr_pkg::S_SUM;
      end
      cqsr_pkg::S_SUM: begin
        cmd.op    = cqsr_pkg::OP_SUM;
        state_nxt = cqsr_pkg::S_NORM;
      end
      cqsr_pkg::S_NORM: begin
        cmd.op = cqsr_pkg::OP_NORM;
        if (stat.done) begin
          case (phase_r)
            cqsr_pkg::PH_A: state_nxt = cqsr_pkg::S_XB;
            cqsr_pkg::PH_B: state_nxt = cqsr_pkg::S_TEST;
            default: begin
              iters_nxt = iters_r + 1'b1;
              state_nxt = cqsr_pkg::S_CHKTOL;
            end
          endcase
        end
      end
      cqsr_pkg::S_XB: begin
        cmd.op    = cqsr_pkg::OP_XB;
        phase_nxt = cqsr_pkg::PH_B;
        state_nxt = cqsr_pkg::S_SQ;
      end
      cqsr_pkg::S_TEST: begin
        if (iters_r < max_it) begin
          state_nxt = cqsr_pkg::S_SWAP;
        end else begin
          status_nxt    = cqsr_pkg::ST_LIMIT;
          rootb_nxt     = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = cqsr_pkg::S_IDLE;
        end
      end
      cqsr_pkg::S_SWAP: begin
        cmd.op    = cqsr_pkg::OP_SWAP;
        state_nxt = cqsr_pkg::S_DE;
      end
      cqsr_pkg::S_DE: begin
        cmd.op    = cqsr_pkg::OP_DE;
        state_nxt = cqsr_pkg::S_NORME;
      end
      cqsr_pkg::S_NORME: begin
        cmd.op = cqsr_pkg::OP_NORME;
        if (stat.done) state_nxt = cqsr_pkg::S_CHKZ;
      end
      cqsr_pkg::S_CHKZ: begin
        if (stat.ut_zero) begin
          status_nxt    = cqsr_pkg::ST_ZERO;
          rootb_nxt     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = cqsr_pkg::S_IDLE;
        end else begin
          state_nxt = cqsr_pkg::S_NUM;
        end
      end
      cqsr_pkg::S_NUM: begin
        cmd.op = cqsr_pkg::OP_NUM;
        if (stat.done) state_nxt = cqsr_pkg::S_DIVRE;
      end
      cqsr_pkg::S_DIVRE: begin
        cmd.op = cqsr_pkg::OP_DIVRE;
        if (stat.done) state_nxt = cqsr_pkg::S_DIVIM;
      end
      cqsr_pkg::S_DIVIM: begin
        cmd.op = cqsr_pkg::OP_DIVIM;
        if (stat.done) state_nxt = cqsr_pkg::S_ZF;
      end
      cqsr_pkg::S_ZF: begin
        cmd.op = cqsr_pkg::OP_ZF;
        if (stat.done) state_nxt = cqsr_pkg::S_UPD;
      end
      cqsr_pkg::S_UPD: begin
        cmd.op    = cqsr_pkg::OP_UPD;
        phase_nxt = cqsr_pkg::PH_UPD;
        state_nxt = cqsr_pkg::S_SQ;
      end
      cqsr_pkg::S_CHKTOL: begin
        if (stat.conv) begin
          status_nxt    = cqsr_pkg::ST_CONV;
          rootb_nxt     = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = cqsr_pkg::S_IDLE;
        end else begin
          state_nxt = cqsr_pkg::S_TEST;
        end
      end
      default: state_nxt = cqsr_pkg::S_IDLE;
    endcase
  end

  assign busy      = (state_r != cqsr_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign iters     = iters_r;
  assign status    = status_r;

endmodule

@@ hdl/cqsr_dp.sv @@
module cqsr_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cqsr_pkg::dp_cmd_t             cmd,
  input  cqsr_pkg::in_item_t            in_item,
  input  cqsr_pkg::cfg_t                cfg,
  output cqsr_pkg::dp_stat_t            stat,
  output cqsr_pkg::word_t               root_re,
  output cqsr_pkg::word_t               root_im,
  output logic [cqsr_pkg::WORD_W-1:0]   residual
);

  localparam int W     = cqsr_pkg::WORD_W;
  localparam int AW    = cqsr_pkg::ACC_W;
  localparam int AX    = AW + 1;
  localparam int PW    = 2 * W;
  localparam int QW    = W + 1;
  localparam int DIV_N = AW + FRAC_BITS;
  localparam int DCW   = $clog2(DIV_N + 1);

  function automatic cqsr_pkg::word_t to_word(input logic signed [AW-1:0] v);
    logic          neg;
    logic [AW-1:0] m;
    logic [AX-1:0] r;
    logic [AX-1:0] lim;
    logic [W-1:0]  rw;
    neg = v[AW-1];
    m   = neg ? AW'(-v) : AW'(v);
    r   = (AX'(m) + (AX'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim = neg ? (AX'(1) << (W - 1)) : ((AX'(1) << (W - 1)) - AX'(1));
    if (r > lim) r = lim;
    rw = r[W-1:0];
    to_word = neg ? cqsr_pkg::word_t'(~rw + 1'b1) : cqsr_pkg::word_t'(rw);
  endfunction

  function automatic logic [W-1:0] resid(input logic [AW-1:0] n);
    logic [AX-1:0] r;
    r = (AX'(n) + (AX'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    resid = (r > AX'({W{1'b1}})) ? {W{1'b1}} : r[W-1:0];
  endfunction

  function automatic cqsr_pkg::word_t sat_add(input cqsr_pkg::word_t a,
                                              input cqsr_pkg::word_t b,
                                              input logic            sub);
    logic signed [W:0] s;
    s = sub ? ($signed({a[W-1], a}) - $signed({b[W-1], b}))
            : ($signed({a[W-1], a}) + $signed({b[W-1], b}));
    if (s[W] != s[W-1]) sat_add = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else sat_add = s[W-1:0];
  endfunction

  cqsr_pkg::cplx_t a_r, b_r, fa_r, fb_r, x_r, t1_r, t2_r, d_r, e_r, z_r;
  logic [AW-1:0]        na_r, nb_r, ut_r;
  logic signed [AW-1:0] nre_r, nim_r;

  logic signed [PW-1:0] prod_r;
  logic                 pneg_r, pim_r, pvalid_r;
  logic signed [AW-1:0] acc_re_r, acc_im_r;
  logic [2:0]           cnt_r;

  logic [DIV_N-1:0]     div_sh_r;
  logic [AX-1:0]        rem_r;
  logic [QW-1:0]        q_r;
  logic                 qsat_r, div_neg_r, div_run_r;
  logic [DCW-1:0]       div_cnt_r;

  cqsr_pkg::cplx_t mx, my, fsel, cres, sum1, sum2;
  cqsr_pkg::word_t p, q;
  logic            pneg, pim, is_mul, mul_done, is_div, div_done, single;
  logic [2:0]      nprod;

  logic signed [AW-1:0] n_sel;
  logic [AW-1:0]        n_mag;
  logic [AX-1:0]        rem_sh, rem_new;
  logic                 ge, qsat_new;
  logic [QW-1:0]        lim, q_new, qv;
  logic [W-1:0]         qw;

  assign fsel = cmd.sel_b ? fb_r : fa_r;

  always_comb begin
    mx     = x_r;
    my     = x_r;
    nprod  = 3'd4;
    is_mul = 1'b1;
    case (cmd.op)
      cqsr_pkg::OP_SQ: begin
        mx = x_r;
        my = x_r;
      end
      cqsr_pkg::OP_C1: begin
        mx = cfg.c1;
        my = x_r;
      end
      cqsr_pkg::OP_C2: begin
        mx = cfg.c2;
        my = t1_r;
      end
      cqsr_pkg::OP_ZF: begin
        mx = z_r;
        my = fb_r;
      end
      cqsr_pkg::OP_NORM: begin
        mx    = fsel;
        my    = fsel;
        nprod = 3'd2;
      end
      cqsr_pkg::OP_NORME: begin
        mx    = e_r;
        my    = e_r;
        nprod = 3'd2;
      end
      cqsr_pkg::OP_NUM: begin
        mx = d_r;
        my = e_r;
      end
      default: is_mul = 1'b0;
    endcase
    p    = mx.re;
    q    = my.re;
    pneg = 1'b0;
    pim  = 1'b0;
    if (cmd.op == cqsr_pkg::OP_NUM) begin
      case (cnt_r[1:0])
        2'd0: begin
          p = mx.re; q = my.re;
        end
        2'd1: begin
          p = mx.im; q = my.im;
        end
        2'd2: begin
          p = mx.im; q = my.re; pim = 1'b1;
        end
        default: begin
          p = mx.re; q = my.im; pim = 1'b1; pneg = 1'b1;
        end
      endcase
    end else begin
      case (cnt_r[1:0])
        2'd0: begin
          p = mx.re; q = my.re;
        end
        2'd1: begin
          p = mx.im; q = my.im;
          pneg = (cmd.op != cqsr_pkg::OP_NORM) && (cmd.op != cqsr_pkg::OP_NORME);
        end
        2'd2: begin
          p = mx.re; q = my.im; pim = 1'b1;
        end
        default: begin
          p = mx.im; q = my.re; pim = 1'b1;
        end
      endcase
    end
  end

  assign mul_done = is_mul && (cnt_r == nprod + 3'd1);
  assign cres.re  = to_word(acc_re_r);
  assign cres.im  = to_word(acc_im_r);

  // polynomial sum, two saturating adds
  assign sum1.re = sat_add(cfg.c0.re, t2_r.re, 1'b0);
  assign sum1.im = sat_add(cfg.c0.im, t2_r.im, 1'b0);
  assign sum2.re = sat_add(sum1.re, t1_r.re, 1'b0);
  assign sum2.im = sat_add(sum1.im, t1_r.im, 1'b0);

  // restoring divider
  assign is_div   = (cmd.op == cqsr_pkg::OP_DIVRE) || (cmd.op == cqsr_pkg::OP_DIVIM);
  assign div_done = is_div && div_run_r && (div_cnt_r == '0);
  assign n_sel    = (cmd.op == cqsr_pkg::OP_DIVRE) ? nre_r : nim_r;
  assign n_mag    = n_sel[AW-1] ? AW'(-n_sel) : AW'(n_sel);
  assign rem_sh   = {rem_r[AW-1:0], div_sh_r[DIV_N-1]};
  assign ge       = (rem_sh >= {1'b0, ut_r});
  assign rem_new  = ge ? (rem_sh - {1'b0, ut_r}) : rem_sh;
  assign lim      = div_neg_r ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));

  always_comb begin
    q_new    = q_r;
    qsat_new = qsat_r;
    if (!qsat_r) begin
      if (q_r > (lim >> 1)) begin
        qsat_new = 1'b1;
      end else begin
        q_new = {q_r[W-1:0], ge};
        if (q_new > lim) qsat_new = 1'b1;
      end
    end
  end

  assign qv = qsat_r ? lim : q_r;
  assign qw = div_neg_r ? (~qv[W-1:0] + 1'b1) : qv[W-1:0];

  always_comb begin
    case (cmd.op)
      cqsr_pkg::OP_LOAD, cqsr_pkg::OP_XB, cqsr_pkg::OP_SUM,
      cqsr_pkg::OP_SWAP, cqsr_pkg::OP_DE, cqsr_pkg::OP_UPD: single = 1'b1;
      default: single = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      pvalid_r  <= 1'b0;
      div_run_r <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      pvalid_r <= is_mul && (cnt_r < nprod);
      if (is_mul) cnt_r <= mul_done ? 3'd0 : cnt_r + 3'd1;
      else cnt_r <= '0;
      if (is_div && !div_run_r) begin
        div_run_r <= 1'b1;
        div_cnt_r <= DCW'(DIV_N);
      end else if (is_div && div_cnt_r != '0) begin
        div_cnt_r <= div_cnt_r - 1'b1;
      end else if (div_done) begin
        div_run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= p * q;
    pneg_r <= pneg;
    pim_r  <= pim;
    if (cnt_r == 3'd0) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (pvalid_r) begin
      if (pim_r) acc_im_r <= pneg_r ? acc_im_r - AW'(prod_r) : acc_im_r + AW'(prod_r);
      else acc_re_r <= pneg_r ? acc_re_r - AW'(prod_r) : acc_re_r + AW'(prod_r);
    end

    if (is_div && !div_run_r) begin
      div_sh_r  <= {n_mag, {FRAC_BITS{1'b0}}};
      rem_r     <= '0;
      q_r       <= '0;
      qsat_r    <= 1'b0;
      div_neg_r <= n_sel[AW-1];
    end else if (is_div && div_cnt_r != '0) begin
      div_sh_r <= {div_sh_r[DIV_N-2:0], 1'b0};
      rem_r    <= rem_new;
      q_r      <= q_new;
      qsat_r   <= qsat_new;
    end

    if (mul_done) begin
      case (cmd.op)
        cqsr_pkg::OP_C1:    t2_r <= cres;
        cqsr_pkg::OP_NORM: begin
          if (cmd.sel_b) nb_r <= acc_re_r;
          else na_r <= acc_re_r;
        end
        cqsr_pkg::OP_NORME: ut_r <= acc_re_r;
        cqsr_pkg::OP_NUM: begin
          nre_r <= acc_re_r;
          nim_r <= acc_im_r;
        end
        default: t1_r <= cres;
      endcase
    end

    if (div_done) begin
      if (cmd.op == cqsr_pkg::OP_DIVRE) z_r.re <= qw;
      else z_r.im <= qw;
    end

    case (cmd.op)
      cqsr_pkg::OP_LOAD: begin
        a_r.re <= in_item.start_a_re;
        a_r.im <= in_item.start_a_im;
        b_r.re <= in_item.start_b_re;
        b_r.im <= in_item.start_b_im;
        x_r.re <= in_item.start_a_re;
        x_r.im <= in_item.start_a_im;
      end
      cqsr_pkg::OP_XB: x_r <= b_r;
      cqsr_pkg::OP_SUM: begin
        if (cmd.sel_b) fb_r <= sum2;
        else fa_r <= sum2;
      end
      cqsr_pkg::OP_SWAP: begin
        if (na_r < nb_r) begin
          a_r  <= b_r;
          b_r  <= a_r;
          fa_r <= fb_r;
          fb_r <= fa_r;
          na_r <= nb_r;
          nb_r <= na_r;
        end
      end
      cqsr_pkg::OP_DE: begin
        d_r.re <= sat_add(a_r.re, b_r.re, 1'b1);
        d_r.im <= sat_add(a_r.im, b_r.im, 1'b1);
        e_r.re <= sat_add(fb_r.re, fa_r.re, 1'b1);
        e_r.im <= sat_add(fb_r.im, fa_r.im, 1'b1);
      end
      cqsr_pkg::OP_UPD: begin
        a_r.re <= sat_add(b_r.re, t1_r.re, 1'b0);
        a_r.im <= sat_add(b_r.im, t1_r.im, 1'b0);
        x_r.re <= sat_add(b_r.re, t1_r.re, 1'b0);
        x_r.im <= sat_add(b_r.im, t1_r.im, 1'b0);
      end
      default: ;
    endcase
  end

  assign stat.done    = single || mul_done || div_done;
  assign stat.ut_zero = (ut_r == '0);
  assign stat.conv    = (resid(na_r) < cfg.tol);

  assign root_re  = cmd.root_b ? b_r.re : a_r.re;
  assign root_im  = cmd.root_b ? b_r.im : a_r.im;
  assign residual = resid(cmd.root_b ? nb_r : na_r);

endmodule

@@ hdl/complex_quadratic_secant_root.sv @@
// channel   ports                                         handshake
// input     start, busy, in_item                          start && !busy
// result    out_valid, out_item                           out_valid, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data     cfg_valid && cfg_ready
//
// one item at a time; busy stays high until its result strobe
// each secant update: four-product complex multiplies on one shared multiplier
// plus two restoring divisions, one for the real and one for the imaginary part
// synchronous active-low reset restores coefficient defaults; results cannot stall
module complex_quadratic_secant_root #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  cqsr_pkg::in_item_t                in_item,
  output logic                              out_valid,
  output cqsr_pkg::out_item_t               out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cqsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cqsr_pkg::WORD_W-1:0]       cfg_data
);

  localparam int W = cqsr_pkg::WORD_W;

  cqsr_pkg::cfg_t     cfg_r;
  cqsr_pkg::dp_cmd_t  cmd;
  cqsr_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c0.re <= cqsr_pkg::word_t'(W'(1) << FRAC_BITS);
      cfg_r.c0.im <= '0;
      cfg_r.c1.re <= cqsr_pkg::word_t'(W'(2) << FRAC_BITS);
      cfg_r.c1.im <= '0;
      cfg_r.c2.re <= cqsr_pkg::word_t'(W'(3) << FRAC_BITS);
      cfg_r.c2.im <= '0;
      cfg_r.tol   <= W'(1);
      cfg_r.max_it <= cqsr_pkg::ITER_W'(100);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cqsr_pkg::CFG_C0_RE:  cfg_r.c0.re  <= cfg_data;
        cqsr_pkg::CFG_C0_IM:  cfg_r.c0.im  <= cfg_data;
        cqsr_pkg::CFG_C1_RE:  cfg_r.c1.re  <= cfg_data;
        cqsr_pkg::CFG_C1_IM:  cfg_r.c1.im  <= cfg_data;
        cqsr_pkg::CFG_C2_RE:  cfg_r.c2.re  <= cfg_data;
        cqsr_pkg::CFG_C2_IM:  cfg_r.c2.im  <= cfg_data;
        cqsr_pkg::CFG_TOL:    cfg_r.tol    <= cfg_data;
        cqsr_pkg::CFG_MAX_IT: cfg_r.max_it <= cfg_data[cqsr_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  cqsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .max_it    (cfg_r.max_it),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid),
    .iters     (out_item.iterations_used),
    .status    (out_item.status)
  );

  cqsr_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .cfg      (cfg_r),
    .stat     (stat),
    .root_re  (out_item.root_re),
    .root_im  (out_item.root_im),
    .residual (out_item.residual_sq)
  );

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe without a finished item");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.iterations_used <= cfg_r.max_it))
    else $error("iteration count exceeds limit");

  a_conv_tol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == cqsr_pkg::ST_CONV) |-> (out_item.residual_sq < cfg_r.tol))
    else $error("converged status with residual above tolerance");

  a_limit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == cqsr_pkg::ST_LIMIT)
      |-> (out_item.iterations_used == cfg_r.max_it))
    else $error("limit status before limit reached");

endmodule
